// ===== rtl/csrp_pkg.sv =====
`timescale 1ns / 1ps

package csrp_pkg;

  // capture store and byte counter
  localparam int CAP_DEPTH = 16;
  localparam int CAP_AW    = $clog2(CAP_DEPTH);
  localparam int CNT_W     = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // mailbox header length and payload size thresholds (total byte counts)
  localparam logic [CNT_W-1:0] HDR_LEN        = 17'd6;
  localparam logic [CNT_W-1:0] SIZE_SVC_MIN   = 17'd8;
  localparam logic [CNT_W-1:0] SIZE_SDO_MIN   = 17'd12;
  localparam logic [CNT_W-1:0] SIZE_EXPEDITED = 17'd16;

  // sdo command byte codes and fields
  localparam logic [7:0] CMD_ABORT     = 8'h80;
  localparam logic [7:0] CMD_ACK       = 8'h60;
  localparam logic [7:0] CMD_CCS_MASK  = 8'hE0;
  localparam logic [7:0] CMD_CCS_UPL   = 8'h40;
  localparam logic [7:0] CMD_EXP_BIT   = 8'h02;
  localparam logic [7:0] CMD_SIZE_BIT  = 8'h01;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;
  localparam logic [1:0] UNUSED_MASK   = 2'h3;

  // configuration register indexes
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  typedef enum logic [CFG_AW-1:0] {
    CFG_PARSE_MODE   = 3'd0,
    CFG_EXP_INDEX    = 3'd1,
    CFG_EXP_SUBINDEX = 3'd2,
    CFG_COE_TYPE     = 3'd3,
    CFG_RESP_SERVICE = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_SHORT_HEADER   = 4'd1,
    ST_LEN_MISMATCH   = 4'd2,
    ST_NOT_COE        = 4'd3,
    ST_WRONG_SERVICE  = 4'd4,
    ST_PAYLOAD_SHORT  = 4'd5,
    ST_ABORT_NO_CODE  = 4'd6,
    ST_UNSUPPORTED    = 4'd7,
    ST_NOT_FOUR_BYTES = 4'd8,
    ST_BAD_ACK        = 4'd9,
    ST_DL_ABORTED     = 4'd10
  } status_t;

  typedef logic [CAP_DEPTH-1:0][7:0] cap_t;

  typedef struct packed {
    logic        parse_mode;
    logic [15:0] exp_index;
    logic [7:0]  exp_subindex;
    logic [3:0]  coe_type_code;
    logic [3:0]  response_service_code;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] sdo_index;
    logic [7:0]  sdo_subindex;
    logic        aborted;
    logic [31:0] abort_value;
    logic [31:0] upload_data;
    logic [2:0]  data_bytes;
  } verdict_t;

endpackage

// ===== rtl/csrp_verdict.sv =====
`timescale 1ns / 1ps

module csrp_verdict import csrp_pkg::*; (
  input  cap_t             cap,
  input  logic [CNT_W-1:0] size,
  input  cfg_t             cfg,
  output verdict_t         vd
);

  logic [CNT_W-1:0] len_total;
  logic [7:0]       cmd;
  logic [15:0]      idx;
  logic [31:0]      tail;
  logic [1:0]       unused;

  assign len_total = {1'b0, cap[1], cap[0]} + HDR_LEN;
  assign cmd       = cap[8];
  assign idx       = {cap[10], cap[9]};
  assign tail      = {cap[15], cap[14], cap[13], cap[12]};
  assign unused    = cmd[3:2] & UNUSED_MASK;

  always_comb begin
    vd = '0;
    vd.status = ST_OK;
    if (size < HDR_LEN) begin
      vd.status = ST_SHORT_HEADER;
    end else if (size != len_total) begin
      vd.status = ST_LEN_MISMATCH;
    end else if ((cap[5][3:0] & NIBBLE_MASK) != cfg.coe_type_code || size < SIZE_SVC_MIN) begin
      vd.status = ST_NOT_COE;
    end else if (cap[7][7:4] != cfg.response_service_code) begin
      vd.status = ST_WRONG_SERVICE;
    end else if (size < SIZE_SDO_MIN) begin
      vd.status = ST_PAYLOAD_SHORT;
    end else begin
      vd.sdo_index    = idx;
      vd.sdo_subindex = cap[11];
      if (cmd == CMD_ABORT) begin
        vd.aborted = 1'b1;
        if (size < SIZE_EXPEDITED) begin
          vd.status = ST_ABORT_NO_CODE;
        end else begin
          vd.abort_value = tail;
          vd.status      = cfg.parse_mode ? ST_DL_ABORTED : ST_OK;
        end
      end else if (cfg.parse_mode) begin
        if (cmd != CMD_ACK || idx != cfg.exp_index
            || cap[11] != cfg.exp_subindex) begin
          vd.status = ST_BAD_ACK;
        end
      end else if ((cmd & CMD_CCS_MASK) != CMD_CCS_UPL || (cmd & CMD_EXP_BIT) == '0
                   || (cmd & CMD_SIZE_BIT) == '0) begin
        vd.status = ST_UNSUPPORTED;
      end else if (size != SIZE_EXPEDITED) begin
        vd.status = ST_NOT_FOUR_BYTES;
      end else begin
        // expedited upload: drop the unused upper bytes
        vd.data_bytes  = 3'd4 - {1'b0, unused};
        vd.upload_data = tail & (32'hFFFF_FFFF >> {unused, 3'b000});
      end
    end
  end

endmodule

// ===== rtl/coe_sdo_response_mailbox_parser.sv =====
`timescale 1ns / 1ps

// CoE SDO response parser: takes a received mailbox one byte per item, header
// first, and gives one verdict item when the byte flagged by last_byte has
// been taken. Bytes are accepted at one per clock when not stalled. Each byte
// goes into a 16-byte capture register file at the position set by a
// saturating 17-bit byte counter; later bytes are counted only. The verdict
// (header length, length field, CoE type nibble, response service nibble, then
// the upload or download-ack decode) is computed combinationally from the
// capture registers after the last byte is captured, then moves into the output
// register when that is empty or being drained. Input stalls only while a
// verdict is pending and the output register still holds an item not taken.
// Configuration registers (index 0 parse_mode, 1 index to match,
// 2 subindex to match, 3 coe_type_code, 4 response_service_code) are written
// through cfg_we / cfg_index / cfg_wdata and must only change while idle.

module coe_sdo_response_mailbox_parser import csrp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // byte input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  // verdict output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        status,
  output logic [15:0]       sdo_index,
  output logic [7:0]        sdo_subindex,
  output logic              aborted,
  output logic [31:0]       abort_value,
  output logic [31:0]       upload_data,
  output logic [2:0]        data_bytes
);

  cfg_t             cfg;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] count_next;
  cap_t             cap;
  logic [CNT_W-1:0] vsize;        // byte count of the mailbox awaiting a verdict
  logic             vpend;        // last byte captured, verdict not yet loaded
  logic             accept;
  logic             load;
  verdict_t         vd;
  verdict_t         out_q;

  assign accept     = in_valid && in_ready;
  // verdict moves to the output register when it is empty or being drained
  assign load       = vpend && (!out_valid || out_ready);
  // new bytes would overwrite the capture while a verdict is still stuck
  assign in_ready   = !vpend || load;
  assign count_next = (byte_count == CNT_MAX) ? byte_count : byte_count + 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.parse_mode            <= 1'b0;
      cfg.exp_index             <= '0;
      cfg.exp_subindex          <= '0;
      cfg.coe_type_code         <= 4'd3;
      cfg.response_service_code <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PARSE_MODE:   cfg.parse_mode            <= cfg_wdata[0];
        CFG_EXP_INDEX:    cfg.exp_index             <= cfg_wdata[15:0];
        CFG_EXP_SUBINDEX: cfg.exp_subindex          <= cfg_wdata[7:0];
        CFG_COE_TYPE:     cfg.coe_type_code         <= cfg_wdata[3:0];
        CFG_RESP_SERVICE: cfg.response_service_code <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // byte counter and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      vpend      <= 1'b0;
    end else begin
      if (accept) begin
        byte_count <= last_byte ? '0 : count_next;
      end
      // a new last byte in the load cycle opens the next verdict
      if (accept && last_byte) begin
        vpend <= 1'b1;
      end else if (load) begin
        vpend <= 1'b0;
      end
    end
  end

  // capture registers and mailbox size, no reset: only written entries are read
  always_ff @(posedge clk) begin
    if (accept) begin
      if (byte_count < CNT_W'(CAP_DEPTH)) begin
        cap[byte_count[CAP_AW-1:0]] <= data_byte;
      end
      if (last_byte) begin
        vsize <= count_next;
      end
    end
  end

  csrp_verdict u_verdict (
    .cap  (cap),
    .size (vsize),
    .cfg  (cfg),
    .vd   (vd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= vd;
    end
  end

  assign status       = out_q.status;
  assign sdo_index    = out_q.sdo_index;
  assign sdo_subindex = out_q.sdo_subindex;
  assign aborted      = out_q.aborted;
  assign abort_value  = out_q.abort_value;
  assign upload_data  = out_q.upload_data;
  assign data_bytes   = out_q.data_bytes;

  // a last byte opens a verdict and restarts the count
  a_last_opens: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> vpend && byte_count == '0)
    else $error("last byte did not open a verdict");

  // a stuck verdict blocks input and keeps its size
  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    vpend && !load |-> !accept ##1 (vpend && $stable(vsize)))
    else $error("pending verdict disturbed");

  // data bytes only on a clean upload
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_bytes != '0 |-> status == ST_OK && !aborted)
    else $error("data bytes on a failed verdict");

  // abort flag only with abort-related status
  a_abort_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && aborted |-> status == ST_OK || status == ST_ABORT_NO_CODE
                             || status == ST_DL_ABORTED)
    else $error("abort flag with unrelated status");

endmodule
